### design/strint_pkg.sv
// ============================================================================
// strint_pkg: shared types, constants and helper functions
// Item layouts, parser phases, status and register codes, and the character
// classification used by the string to int64 parser.
// ============================================================================
package strint_pkg;

    localparam int unsigned DATA_W = 64;
    localparam int unsigned CNT_W  = 16;
    localparam int unsigned BASE_W = 6;

    // Consumed length saturates here.
    localparam logic [CNT_W-1:0] LENGTH_LIMIT = 16'hFFFF;

    // Status codes.
    localparam logic [1:0] STATUS_OK      = 2'd0;
    localparam logic [1:0] STATUS_INVALID = 2'd1;
    localparam logic [1:0] STATUS_RANGE   = 2'd2;

    // Configuration register indexes.
    localparam logic [1:0] REG_RADIX = 2'd0;
    localparam logic [1:0] REG_LOWER = 2'd1;
    localparam logic [1:0] REG_UPPER = 2'd2;

    // Radix and base values.
    localparam logic [BASE_W-1:0] RADIX_AUTO  = 6'd0;
    localparam logic [BASE_W-1:0] RADIX_UNARY = 6'd1;
    localparam logic [BASE_W-1:0] RADIX_RESET = 6'd10;
    localparam logic [BASE_W-1:0] RADIX_MAX   = 6'd36;
    localparam logic [BASE_W-1:0] BASE_MIN    = 6'd2;
    localparam logic [BASE_W-1:0] BASE_OCT    = 6'd8;
    localparam logic [BASE_W-1:0] BASE_DEC    = 6'd10;
    localparam logic [BASE_W-1:0] BASE_HEX    = 6'd16;
    localparam logic [BASE_W-1:0] NO_DIGIT    = 6'd36;

    // Character codes.
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_LA    = 8'h61;
    localparam logic [7:0] CH_LZ    = 8'h7A;
    localparam logic [7:0] CH_UA    = 8'h41;
    localparam logic [7:0] CH_UZ    = 8'h5A;
    localparam logic [7:0] CH_LX    = 8'h78;
    localparam logic [7:0] CH_UX    = 8'h58;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] LETTER_OFFSET = 8'd10;

    typedef enum logic [6:0] {
        PH_IDLE   = 7'b0000001,
        PH_LEAD   = 7'b0000010,
        PH_SIGNED = 7'b0000100,
        PH_ZERO   = 7'b0001000,
        PH_PREFIX = 7'b0010000,
        PH_DIGITS = 7'b0100000,
        PH_OVER   = 7'b1000000
    } phase_t;

    typedef struct packed {
        logic       start_req;
        logic [7:0] char_code;
    } in_item_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] value;
        logic [1:0]               status;
        logic [CNT_W-1:0]         end_offset;
    } out_item_t;

    typedef struct packed {
        phase_t              phase;
        logic                negative;
        logic [DATA_W-1:0]   accumulator;
        logic [BASE_W-1:0]   active_base;
        logic [CNT_W-1:0]    consumed;
    } parse_state_t;

    // Digit value of a character in bases up to 36, NO_DIGIT for anything else.
    function automatic logic [BASE_W-1:0] digit_of(input logic [7:0] ch);
        logic [7:0] d;
        d = 8'(NO_DIGIT);
        if (ch >= CH_0 && ch <= CH_9) begin
            d = ch - CH_0;
        end else if (ch >= CH_LA && ch <= CH_LZ) begin
            d = ch - CH_LA + LETTER_OFFSET;
        end else if (ch >= CH_UA && ch <= CH_UZ) begin
            d = ch - CH_UA + LETTER_OFFSET;
        end
        return d[BASE_W-1:0];
    endfunction

    // Space, tab, line feed, vertical tab, form feed and carriage return.
    function automatic logic is_space(input logic [7:0] ch);
        return (ch == CH_SPACE) || (ch >= CH_TAB && ch <= CH_CR);
    endfunction

endpackage

### design/strint_mac.sv
// ============================================================================
// strint_mac: digit multiply-add with exact bound check
// Forms accumulator * base + digit and flags a result above the magnitude
// bound.
// ============================================================================
module strint_mac
    import strint_pkg::*;
(
    input  logic [DATA_W-1:0] acc,
    input  logic [BASE_W-1:0] base,
    input  logic [BASE_W-1:0] digit,
    input  logic [DATA_W-1:0] bound,
    output logic [DATA_W-1:0] acc_next,
    output logic              overflow
);

    localparam int unsigned WIDE_W = DATA_W + BASE_W;

    logic [BASE_W-1:0] base_eff;
    logic [WIDE_W-1:0] product;
    logic [WIDE_W-1:0] sum;

    // A base below two only arises after a radix change mid-string; it counts as two.
    assign base_eff = (base < BASE_MIN) ? BASE_MIN : base;
    assign product  = WIDE_W'(acc) * WIDE_W'(base_eff);
    assign sum      = product + WIDE_W'(digit);
    assign overflow = sum > WIDE_W'(bound);
    assign acc_next = sum[DATA_W-1:0];

endmodule

### design/strint_step.sv
// ============================================================================
// strint_step: per-character parse step
// Works out the next parser state and any result for one character.
// ============================================================================
module strint_step
    import strint_pkg::*;
(
    input  in_item_t                 item,
    input  parse_state_t             state_in,
    input  logic [BASE_W-1:0]        radix,
    input  logic signed [DATA_W-1:0] lower_limit,
    input  logic signed [DATA_W-1:0] upper_limit,
    output parse_state_t             state_out,
    output logic                     emit,
    output out_item_t                result
);

    parse_state_t      eff;
    logic              radix_bad;
    logic [BASE_W-1:0] digit;
    logic [BASE_W-1:0] first_base;
    logic [BASE_W-1:0] base_sel;
    logic [DATA_W-1:0] bound;
    logic [DATA_W-1:0] mac_acc;
    logic              mac_ovf;
    logic              in_run;

    // A start character restarts the parse before it is itself examined.
    always_comb begin
        eff = state_in;
        if (item.start_req) begin
            eff.phase       = PH_LEAD;
            eff.negative    = 1'b0;
            eff.accumulator = '0;
            eff.active_base = '0;
            eff.consumed    = '0;
        end
    end

    assign radix_bad  = (radix == RADIX_UNARY) || (radix > RADIX_MAX);
    assign digit      = digit_of(item.char_code);
    assign first_base = (radix == RADIX_AUTO) ? BASE_DEC : radix;

    always_comb begin
        case (eff.phase)
            PH_LEAD, PH_SIGNED: begin
                base_sel = first_base;
            end
            PH_ZERO: begin
                base_sel = (radix == RADIX_AUTO) ? BASE_OCT : BASE_HEX;
            end
            PH_PREFIX: begin
                base_sel = BASE_HEX;
            end
            default: begin
                base_sel = eff.active_base;
            end
        endcase
    end

    // A limit of the wrong sign allows no magnitude on its side.
    always_comb begin
        if (eff.negative) begin
            if (!lower_limit[DATA_W-1] && lower_limit != '0) begin
                bound = '0;
            end else begin
                bound = '0 - DATA_W'(lower_limit);
            end
        end else begin
            bound = upper_limit[DATA_W-1] ? '0 : DATA_W'(upper_limit);
        end
    end

    assign in_run = digit < base_sel;

    strint_mac u_mac (
        .acc      (eff.accumulator),
        .base     (base_sel),
        .digit    (digit),
        .bound    (bound),
        .acc_next (mac_acc),
        .overflow (mac_ovf)
    );

    always_comb begin
        logic do_first;
        logic do_run;
        logic is_sign;
        logic zero_prefix;
        state_out = eff;
        emit      = 1'b0;
        result    = '0;
        do_first  = 1'b0;
        do_run    = 1'b0;
        is_sign   = (item.char_code == CH_PLUS) || (item.char_code == CH_MINUS);
        zero_prefix = (item.char_code == CH_0)
                      && ((radix == RADIX_AUTO) || (radix == BASE_HEX));
        if (item.start_req && radix_bad) begin
            emit          = 1'b1;
            result.status = STATUS_INVALID;
            state_out.phase = PH_IDLE;
        end else if (eff.phase != PH_IDLE) begin
            case (eff.phase)
                PH_LEAD: begin
                    if (is_space(item.char_code)) begin
                        state_out.phase = PH_LEAD;
                    end else if (is_sign) begin
                        state_out.negative = (item.char_code == CH_MINUS);
                        state_out.phase    = PH_SIGNED;
                    end else begin
                        do_first = 1'b1;
                    end
                end
                PH_SIGNED: begin
                    do_first = 1'b1;
                end
                PH_ZERO: begin
                    if (item.char_code == CH_LX || item.char_code == CH_UX) begin
                        state_out.phase = PH_PREFIX;
                    end else begin
                        do_run = 1'b1;
                    end
                end
                PH_PREFIX: begin
                    state_out.active_base = BASE_HEX;
                    if (in_run) begin
                        do_run = 1'b1;
                    end else begin
                        // "0x" with no hex digit: only the zero is consumed.
                        emit = 1'b1;
                        result.status = STATUS_OK;
                        result.end_offset = (eff.consumed >= LENGTH_LIMIT) ?
                                            LENGTH_LIMIT : eff.consumed - 1'b1;
                        state_out.phase = PH_IDLE;
                    end
                end
                default: begin
                    do_run = 1'b1;
                end
            endcase

            if (do_first && zero_prefix) begin
                state_out.accumulator = '0;
                state_out.phase       = PH_ZERO;
            end else if (do_first || do_run) begin
                state_out.active_base = base_sel;
                if (in_run) begin
                    if (eff.phase == PH_OVER) begin
                        state_out.phase = PH_OVER;
                    end else if (mac_ovf) begin
                        state_out.phase = PH_OVER;
                    end else begin
                        state_out.accumulator = mac_acc;
                        state_out.phase       = PH_DIGITS;
                    end
                end else begin
                    emit = 1'b1;
                    state_out.phase = PH_IDLE;
                    if (do_first) begin
                        result.status = STATUS_OK;
                    end else if (eff.phase == PH_OVER) begin
                        result.value      = eff.negative ? lower_limit : upper_limit;
                        result.status     = STATUS_RANGE;
                        result.end_offset = eff.consumed;
                    end else begin
                        result.value      = eff.negative ? ('0 - eff.accumulator)
                                                         : eff.accumulator;
                        result.status     = STATUS_OK;
                        result.end_offset = eff.consumed;
                    end
                end
            end

            if (eff.consumed < LENGTH_LIMIT) begin
                state_out.consumed = eff.consumed + 1'b1;
            end
        end
    end

endmodule

### design/string_to_int64_parser.sv
// ============================================================================
// string_to_int64_parser: streaming signed 64-bit integer parser
// Parses one character per item in the manner of strtoll and returns one
// result per string: value, status and consumed length.
// ============================================================================
// The parser takes one character per cycle unless a waiting result holds it
// up, and answers with one result for each string, at the first character
// that cannot continue the number (or at once on the start character when
// the radix is invalid). An accepted character is held in the input register;
// the parse step, whose longest path is the 64 by 6 bit multiply-add and exact
// bound compare in strint_mac, then updates the parser state and, where the
// string ends, loads the result register when the step runs, so a result
// follows its closing character through both of these registers, and
// while results are taken promptly a character can be accepted in every cycle.
// The step only runs while the result register is free or is being emptied, so
// a result left waiting lets one further character into the input register and
// then holds the input until the result is taken.
// Characters arriving with no string open are taken and ignored. The block
// keeps no memories and needs no clearing pass. The user must write the radix
// and limit registers via the plain write port while idle; it is not enforced.
module string_to_int64_parser
    import strint_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  in_item_t            s_item,
    output logic                m_valid,
    input  logic                m_ready,
    output out_item_t           m_item,
    input  logic                cfg_wr_en,
    input  logic [1:0]          cfg_index,
    input  logic [DATA_W-1:0]   cfg_wr_data
);

    // Input register.
    in_item_t     in_item_reg;
    logic         in_valid_reg;
    logic         in_valid_next;

    // Parser state.
    parse_state_t state_reg;
    parse_state_t state_next;

    // Configuration.
    logic [BASE_W-1:0]        radix_reg;
    logic signed [DATA_W-1:0] lower_limit_reg;
    logic signed [DATA_W-1:0] upper_limit_reg;

    // Result register.
    out_item_t    out_item_reg;
    logic         out_valid_reg;
    logic         out_valid_next;

    logic         step_fire;
    logic         step_emit;
    out_item_t    step_result;
    logic         in_take;

    // The step runs whenever a character is held and the result register is
    // free or is being emptied in this cycle.
    assign step_fire = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready   = !in_valid_reg || step_fire;
    assign in_take   = s_valid && s_ready;

    strint_step u_step (
        .item        (in_item_reg),
        .state_in    (state_reg),
        .radix       (radix_reg),
        .lower_limit (lower_limit_reg),
        .upper_limit (upper_limit_reg),
        .state_out   (state_next),
        .emit        (step_emit),
        .result      (step_result)
    );

    always_comb begin
        if (in_take) begin
            in_valid_next = 1'b1;
        end else if (step_fire) begin
            in_valid_next = 1'b0;
        end else begin
            in_valid_next = in_valid_reg;
        end
    end

    always_comb begin
        if (step_fire && step_emit) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg          <= 1'b0;
            out_valid_reg         <= 1'b0;
            state_reg.phase       <= PH_IDLE;
            state_reg.negative    <= 1'b0;
            state_reg.accumulator <= '0;
            state_reg.active_base <= '0;
            state_reg.consumed    <= '0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (step_fire) begin
                state_reg <= state_next;
            end
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge aclk) begin
        if (in_take) begin
            in_item_reg <= s_item;
        end
        if (step_fire && step_emit) begin
            out_item_reg <= step_result;
        end
    end

    // Configuration writes; an index beyond the register list is dropped.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            radix_reg       <= RADIX_RESET;
            lower_limit_reg <= {1'b1, {(DATA_W-1){1'b0}}};
            upper_limit_reg <= {1'b0, {(DATA_W-1){1'b1}}};
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_RADIX: begin
                    radix_reg <= cfg_wr_data[BASE_W-1:0];
                end
                REG_LOWER: begin
                    lower_limit_reg <= cfg_wr_data;
                end
                REG_UPPER: begin
                    upper_limit_reg <= cfg_wr_data;
                end
                default: begin
                    radix_reg <= radix_reg;
                end
            endcase
        end
    end

    assign m_valid = out_valid_reg;
    assign m_item  = out_item_reg;

`ifndef ASSERT_OFF
    // An invalid radix on a start character gives an invalid-base result next.
    a_invalid_radix: assert property (@(posedge aclk) disable iff (!aresetn)
        step_fire && in_item_reg.start_req
        && (radix_reg == RADIX_UNARY || radix_reg > RADIX_MAX)
        |=> m_valid && m_item.status == STATUS_INVALID)
        else $error("invalid radix did not produce an invalid-base result");

    // Once a result is produced the string is closed.
    a_idle_after_result: assert property (@(posedge aclk) disable iff (!aresetn)
        step_fire && step_emit |=> state_reg.phase == PH_IDLE)
        else $error("parser still open after its result");

    // A result only appears from a step of the parser.
    a_result_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(out_valid_reg) |-> $past(step_fire && step_emit))
        else $error("result appeared without a parse step");

    // With the result register empty the input side never stalls.
    a_no_needless_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        !out_valid_reg |-> s_ready)
        else $error("input stalled with an empty result register");
`endif

endmodule
